/* design/srlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlp_pkg: shared definitions for the suffix rule line parser
// Character codes, line kind and error codes, field widths and the record
// that holds the per-line parse state.
// ----------------------------------------------------------------------------
package srlp_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int ERR_W   = 3;
    localparam int LBL_W   = 6;
    localparam int COL_W   = 2;
    localparam int CNT_W   = 32;
    localparam int OUT_CNT_W = 32;
    localparam int NUM_KINDS = 4;

    // Label count saturates here
    localparam logic [LBL_W-1:0] MAX_LABELS = LBL_W'(63);

    // Column saturates at two: only the first two bytes matter
    localparam logic [COL_W-1:0] COL_FIRST  = COL_W'(0);
    localparam logic [COL_W-1:0] COL_SECOND = COL_W'(1);
    localparam logic [COL_W-1:0] COL_LATER  = COL_W'(2);

    // Characters that steer the parse
    localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_BANG  = 8'd33;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'd42;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'd46;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'd47;

    // Line kinds
    localparam logic [KIND_W-1:0] KIND_RULE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPACE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMMENT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_SLASH    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_ADJACENT = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TRAILING = 3'd4;

    // Output word layout: tdata bits used and padded width
    localparam int OUT_USED_W = ERR_W + 2 + LBL_W + NUM_KINDS * OUT_CNT_W;
    localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

    // Per-line parse state
    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [BYTE_W-1:0] first_byte;
        logic              is_comment;
        logic              seen_non_space;
        logic              before_first_space;
        logic              exception_flag;
        logic              wildcard_flag;
        logic              label_open;
        logic [LBL_W-1:0]  labels_seen;
        logic [ERR_W-1:0]  first_error;
    } t_line;

    localparam t_line LINE_CLEAR = '{
        column:             COL_FIRST,
        first_byte:         '0,
        is_comment:         1'b0,
        seen_non_space:     1'b0,
        before_first_space: 1'b1,
        exception_flag:     1'b0,
        wildcard_flag:      1'b0,
        label_open:         1'b0,
        labels_seen:        '0,
        first_error:        ERR_NONE
    };

endpackage

/* design/suffix_rule_line_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_rule_line_parser: streaming classifier for suffix rule-list text
// Takes one text byte per word and reports one result word per finished line.
// ----------------------------------------------------------------------------
// Each input word carries one byte of text; a newline byte or tlast finishes
// the line. The block accepts one byte every clock cycle whenever its output
// register is empty or being emptied, so the rate is one byte per cycle; the
// result is registered and appears in the cycle after the byte that finishes
// its line. The per-line flags and the four kind counters update through short
// combinational logic from the line registers to the result register; the only
// stall comes from the downstream side holding tready low while a result waits.
module suffix_rule_line_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [srlp_pkg::BYTE_W-1:0]      i_s_tdata,   // [7:0] text_byte
    input  logic                             i_s_tlast,   // end_of_text
    // Result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [2:0] error_code, [3] exception_rule, [4] wildcard_rule, [10:5] label_count,
    // [42:11] rule_lines, [74:43] whitespace_lines, [106:75] comment_lines,
    // [138:107] invalid_lines, [143:139] zero
    output logic [srlp_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic [srlp_pkg::KIND_W-1:0]      o_m_tuser    // [1:0] line_kind
);
    import srlp_pkg::*;

    t_line                r_line, n_line;
    t_line                taken, view;
    logic [CNT_W-1:0]     r_cnt [NUM_KINDS];
    logic [CNT_W-1:0]     n_cnt [NUM_KINDS];
    logic                 r_valid;
    logic [KIND_W-1:0]    r_kind;
    logic [ERR_W-1:0]     r_err;
    logic                 r_exc, r_wild;
    logic [LBL_W-1:0]     r_labels;
    logic [OUT_CNT_W-1:0] r_out_cnt [NUM_KINDS];

    logic                 in_acc, is_nl, fin, feed;
    logic [BYTE_W-1:0]    c;
    logic [KIND_W-1:0]    n_kind;
    logic [ERR_W-1:0]     n_err;
    logic                 n_exc, n_wild;
    logic [LBL_W-1:0]     n_labels;
    logic [LBL_W:0]       lbl_sum;

    // Handshake: the output register parts the two sides
    assign o_s_tready = !r_valid || i_m_tready;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign c          = i_s_tdata;
    assign is_nl      = (c == CH_NL);
    assign fin        = is_nl || i_s_tlast;

    // Line state after taking one ordinary byte
    always_comb begin
        taken = r_line;
        feed  = 1'b1;
        if (r_line.column == COL_FIRST) begin
            taken.first_byte = c;
        end
        if (r_line.column == COL_SECOND && r_line.first_byte == CH_SLASH
                && c == CH_SLASH) begin
            taken.is_comment = 1'b1;
        end
        if (c != CH_SPACE) begin
            taken.seen_non_space = 1'b1;
        end
        if (r_line.before_first_space) begin
            if (c == CH_SPACE) begin
                taken.before_first_space = 1'b0;
            end else begin
                if (r_line.column == COL_FIRST) begin
                    if (c == CH_STAR) begin
                        taken.wildcard_flag = 1'b1;
                    end else if (c == CH_BANG) begin
                        taken.exception_flag = 1'b1;
                        feed = 1'b0;
                    end else if (c == CH_SLASH) begin
                        if (r_line.first_error == ERR_NONE) begin
                            taken.first_error = ERR_SLASH;
                        end
                        feed = 1'b0;
                    end
                end
                if (feed) begin
                    if (c == CH_DOT) begin
                        if (!r_line.label_open) begin
                            if (r_line.first_error == ERR_NONE) begin
                                taken.first_error = ERR_ADJACENT;
                            end
                        end else if (r_line.labels_seen < MAX_LABELS) begin
                            taken.labels_seen = r_line.labels_seen + LBL_W'(1);
                        end
                        taken.label_open = 1'b0;
                    end else begin
                        taken.label_open = 1'b1;
                    end
                end
            end
        end
        if (r_line.column != COL_LATER) begin
            taken.column = r_line.column + COL_W'(1);
        end
    end

    // A newline finishes the line as it stands; any other byte is taken first
    assign view = is_nl ? r_line : taken;

    // Classify the finished line
    always_comb begin
        n_err    = ERR_NONE;
        n_exc    = 1'b0;
        n_wild   = 1'b0;
        n_labels = '0;
        lbl_sum  = {1'b0, view.labels_seen} + (LBL_W+1)'(1);
        if (view.is_comment) begin
            n_kind = KIND_COMMENT;
        end else if (!view.seen_non_space) begin
            n_kind = KIND_SPACE;
        end else if (view.first_byte == CH_SPACE) begin
            n_kind = KIND_INVALID;
            n_err  = ERR_EMPTY;
        end else if (view.first_error != ERR_NONE) begin
            n_kind = KIND_INVALID;
            n_err  = view.first_error;
        end else if (!view.label_open) begin
            n_kind = KIND_INVALID;
            n_err  = ERR_TRAILING;
        end else begin
            n_kind   = KIND_RULE;
            n_exc    = view.exception_flag;
            n_wild   = view.wildcard_flag;
            n_labels = (lbl_sum > {1'b0, MAX_LABELS}) ? MAX_LABELS : lbl_sum[LBL_W-1:0];
        end
    end

    // Kind counters: the reported kind advances by one, wrapping
    always_comb begin
        for (int k = 0; k < NUM_KINDS; k++) begin
            n_cnt[k] = r_cnt[k];
            if (n_kind == KIND_W'(k)) begin
                n_cnt[k] = r_cnt[k] + CNT_W'(1);
            end
        end
    end

    // Next line state
    assign n_line = fin ? LINE_CLEAR : taken;

    // Line state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= LINE_CLEAR;
            for (int k = 0; k < NUM_KINDS; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (in_acc) begin
            r_line <= n_line;
            if (fin) begin
                for (int k = 0; k < NUM_KINDS; k++) begin
                    r_cnt[k] <= n_cnt[k];
                end
            end
        end
    end

    // Output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_acc && fin) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (in_acc && fin) begin
            r_kind   <= n_kind;
            r_err    <= n_err;
            r_exc    <= n_exc;
            r_wild   <= n_wild;
            r_labels <= n_labels;
            for (int k = 0; k < NUM_KINDS; k++) begin
                r_out_cnt[k] <= OUT_CNT_W'(n_cnt[k]);
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tdata  = OUT_DATA_W'({r_out_cnt[3], r_out_cnt[2], r_out_cnt[1],
                                     r_out_cnt[0], r_labels, r_wild, r_exc, r_err});

`ifndef ASSERT_OFF
    // A finishing byte always leaves a result in the output register.
    a_fin_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && fin) |=> o_m_tvalid)
        else $error("finished line produced no result");

    // After a finished line the parse state starts over.
    a_line_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && fin) |=> (r_line.column == COL_FIRST && r_line.before_first_space
                             && !r_line.label_open && r_line.first_error == ERR_NONE))
        else $error("line state not cleared after finish");

    // An error code is reported exactly for invalid lines.
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tuser == KIND_INVALID) == (o_m_tdata[ERR_W-1:0] != ERR_NONE)))
        else $error("error code does not match line kind");

    // With the output register empty the input side is never held off.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output register");
`endif

endmodule

/* verif/suffix_rule_line_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_rule_line_parser_tb: self-checking bench for the rule line parser
// Streams rule-list text into the parser one byte per word. A behavioral line
// classifier in the bench predicts the kind, the error code, the rule flags,
// the label count and the running kind counters of every finished line. Each
// result word is checked field by field against the oldest prediction. A
// short directed table comes first, then random well-formed and broken lines,
// with random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module suffix_rule_line_parser_tb;
    import srlp_pkg::*;

    localparam int TEXT_BYTES  = 850;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 10;
    localparam int MAX_REPORTS = 30;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [BYTE_W-1:0]        i_s_tdata;
    logic                     i_s_tlast;
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [OUT_DATA_W-1:0]    o_m_tdata;
    logic [KIND_W-1:0]        o_m_tuser;

    suffix_rule_line_parser u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [7:0] text_byte
        .i_s_tlast  (i_s_tlast),   // end_of_text
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [2:0] err, [3] exc, [4] wild, [10:5] labels, counters
        .o_m_tuser  (o_m_tuser)    // [1:0] line_kind
    );

    // One classified line as the parser should report it.
    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [ERR_W-1:0]     err;
        logic                 exc;
        logic                 wild;
        logic [LBL_W-1:0]     labels;
        logic [OUT_CNT_W-1:0] tally [NUM_KINDS];
    } line_result_t;

    // One row of the directed text; the line fields are only used when
    // the row finishes a line and carries a hand-written expectation.
    typedef struct packed {
        logic [BYTE_W-1:0] text;
        logic              eot;
        logic              typed;
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
        logic              exc;
        logic              wild;
        logic [LBL_W-1:0]  labels;
    } text_row_t;

    line_result_t pending_lines [$];
    text_row_t    directed_rows [24];
    logic [7:0]   line_text [$];

    // Line classifier state.
    logic [COL_W-1:0]     ln_col;
    logic [BYTE_W-1:0]    ln_first;
    logic                 ln_comment;
    logic                 ln_nonspace;
    logic                 ln_pre_space;
    logic                 ln_exc;
    logic                 ln_wild;
    logic                 ln_open;
    logic [LBL_W-1:0]     ln_labels;
    logic [ERR_W-1:0]     ln_err;
    logic [OUT_CNT_W-1:0] kind_tally [NUM_KINDS];

    int fail_count;
    int lines_checked;
    int bytes_sent;
    int burst_left;
    int idle_cycles;
    int cycle_count;
    int stall_mode;
    int stall_left;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Reports one mismatch and counts it; only the first few are printed.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < MAX_REPORTS) begin
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        end
        fail_count++;
    endtask

    task automatic clear_line_state();
        ln_col       = COL_FIRST;
        ln_first     = '0;
        ln_comment   = 1'b0;
        ln_nonspace  = 1'b0;
        ln_pre_space = 1'b1;
        ln_exc       = 1'b0;
        ln_wild      = 1'b0;
        ln_open      = 1'b0;
        ln_labels    = '0;
        ln_err       = ERR_NONE;
    endtask

    // Folds one text byte (not a newline) into the open line.
    task automatic scan_byte(input logic [BYTE_W-1:0] c);
        logic feed;
        feed = 1'b1;
        if (ln_col == COL_FIRST) ln_first = c;
        if (ln_col == COL_SECOND && ln_first == CH_SLASH && c == CH_SLASH) ln_comment = 1'b1;
        if (c != CH_SPACE) ln_nonspace = 1'b1;
        if (ln_pre_space) begin
            if (c == CH_SPACE) begin
                ln_pre_space = 1'b0;
            end else begin
                if (ln_col == COL_FIRST) begin
                    if (c == CH_STAR) begin
                        ln_wild = 1'b1;
                    end else if (c == CH_BANG) begin
                        ln_exc = 1'b1;
                        feed   = 1'b0;
                    end else if (c == CH_SLASH) begin
                        if (ln_err == ERR_NONE) ln_err = ERR_SLASH;
                        feed = 1'b0;
                    end
                end
                if (feed) begin
                    if (c == CH_DOT) begin
                        if (!ln_open) begin
                            if (ln_err == ERR_NONE) ln_err = ERR_ADJACENT;
                        end else if (ln_labels < MAX_LABELS) begin
                            ln_labels++;
                        end
                        ln_open = 1'b0;
                    end else begin
                        ln_open = 1'b1;
                    end
                end
            end
        end
        if (ln_col != COL_LATER) ln_col++;
    endtask

    // Classifies the open line, bumps its kind counter and clears the line.
    task automatic classify_line(output line_result_t r);
        logic [LBL_W:0] total;
        total    = {1'b0, ln_labels} + (LBL_W+1)'(1);
        r.err    = ERR_NONE;
        r.exc    = 1'b0;
        r.wild   = 1'b0;
        r.labels = '0;
        if (ln_comment) begin
            r.kind = KIND_COMMENT;
        end else if (!ln_nonspace) begin
            r.kind = KIND_SPACE;
        end else if (ln_first == CH_SPACE) begin
            r.kind = KIND_INVALID;
            r.err  = ERR_EMPTY;
        end else if (ln_err != ERR_NONE) begin
            r.kind = KIND_INVALID;
            r.err  = ln_err;
        end else if (!ln_open) begin
            r.kind = KIND_INVALID;
            r.err  = ERR_TRAILING;
        end else begin
            r.kind   = KIND_RULE;
            r.exc    = ln_exc;
            r.wild   = ln_wild;
            r.labels = (total > {1'b0, MAX_LABELS}) ? MAX_LABELS : total[LBL_W-1:0];
        end
        kind_tally[r.kind] = kind_tally[r.kind] + OUT_CNT_W'(1);
        for (int k = 0; k < NUM_KINDS; k++) r.tally[k] = kind_tally[k];
        clear_line_state();
    endtask

    // Sends one text word in the current burst and waits until it is taken.
    // The expected line, if the word finishes one, is queued on acceptance.
    task automatic send_text(input text_row_t row);
        line_result_t r;
        logic         done;
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                      : $urandom_range(1, 12);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= row.text;
        i_s_tlast  <= row.eot;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        burst_left--;
        bytes_sent++;

        done = 1'b0;
        if (row.text == CH_NL) begin
            done = 1'b1;
        end else begin
            scan_byte(row.text);
            done = row.eot;
        end
        if (done) begin
            classify_line(r);
            if (row.typed) begin
                r.kind   = row.kind;
                r.err    = row.err;
                r.exc    = row.exc;
                r.wild   = row.wild;
                r.labels = row.labels;
            end
            pending_lines.insert(pending_lines.size(), r);
        end
    endtask

    function automatic logic [7:0] label_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_NL || c == CH_SPACE || c == CH_DOT) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_NL) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 9))
            0: return CH_SPACE;
            1: return CH_DOT;
            2: return CH_STAR;
            3: return CH_BANG;
            4: return CH_SLASH;
            default: return junk_char();
        endcase
    endfunction

    // Appends one byte to the end of the line being built.
    task automatic add_text(input logic [7:0] b);
        line_text.insert(line_text.size(), b);
    endtask

    // Builds a rule line into line_text; a broken rule gets one defect.
    task automatic build_rule(input logic broken);
        int n_labels;
        int len;
        n_labels = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 4);
        for (int i = 0; i < n_labels; i++) begin
            if (i > 0) add_text(CH_DOT);
            len = (n_labels > 8) ? 1 : $urandom_range(1, 3);
            for (int j = 0; j < len; j++) add_text(label_char());
        end
        case ($urandom_range(0, 5))
            0: line_text.push_front(CH_BANG);
            1: begin
                line_text.push_front(CH_DOT);
                line_text.push_front(CH_STAR);
            end
            2: line_text.push_front(CH_STAR);
            default: ;
        endcase
        if (broken) begin
            case ($urandom_range(0, 3))
                0: line_text.push_front(CH_SPACE);
                1: line_text.push_front(CH_SLASH);
                2: add_text(CH_DOT);
                default: line_text.insert($urandom_range(0, line_text.size()), CH_DOT);
            endcase
        end
        // Text after the first space is ignored by the parser.
        if ($urandom_range(0, 3) == 0) begin
            add_text(CH_SPACE);
            repeat ($urandom_range(0, 4)) add_text(junk_char());
        end
    endtask

    // Builds one random line and sends it with its terminator.
    task automatic send_random_line();
        int        pick;
        int        ending;
        text_row_t row;
        line_text.delete();
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            build_rule(1'b0);
        end else if (pick < 65) begin
            add_text(CH_SLASH);
            add_text(CH_SLASH);
            repeat ($urandom_range(0, 6)) add_text(junk_char());
        end else if (pick < 75) begin
            repeat ($urandom_range(0, 3)) add_text(CH_SPACE);
        end else if (pick < 87) begin
            build_rule(1'b1);
        end else begin
            repeat ($urandom_range(1, 8)) add_text(noise_char());
        end

        // Most lines end in a newline; some end on end of text instead.
        ending = $urandom_range(0, 9);
        row    = '0;
        foreach (line_text[i]) begin
            row.text = line_text[i];
            row.eot  = (ending == 0) && (i == line_text.size() - 1);
            send_text(row);
        end
        if (ending != 0 || line_text.size() == 0) begin
            row.text = CH_NL;
            row.eot  = (ending == 1);
            send_text(row);
        end
    endtask

    // Result side: check every accepted word against the oldest prediction.
    always @(posedge i_clk) begin
        line_result_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_lines.size() == 0) begin
                report_mismatch("result word with no line pending", o_m_tuser, -1);
            end else begin
                want = pending_lines.pop_front();
                lines_checked++;
                if (o_m_tuser != want.kind)
                    report_mismatch("line_kind", o_m_tuser, want.kind);
                if (o_m_tdata[2:0] != want.err)
                    report_mismatch("error_code", o_m_tdata[2:0], want.err);
                if (o_m_tdata[3] != want.exc)
                    report_mismatch("exception_rule", o_m_tdata[3], want.exc);
                if (o_m_tdata[4] != want.wild)
                    report_mismatch("wildcard_rule", o_m_tdata[4], want.wild);
                if (o_m_tdata[10:5] != want.labels)
                    report_mismatch("label_count", o_m_tdata[10:5], want.labels);
                if (o_m_tdata[42:11] != want.tally[KIND_RULE])
                    report_mismatch("rule_lines", o_m_tdata[42:11], want.tally[KIND_RULE]);
                if (o_m_tdata[74:43] != want.tally[KIND_SPACE])
                    report_mismatch("whitespace_lines", o_m_tdata[74:43],
                                    want.tally[KIND_SPACE]);
                if (o_m_tdata[106:75] != want.tally[KIND_COMMENT])
                    report_mismatch("comment_lines", o_m_tdata[106:75],
                                    want.tally[KIND_COMMENT]);
                if (o_m_tdata[138:107] != want.tally[KIND_INVALID])
                    report_mismatch("invalid_lines", o_m_tdata[138:107],
                                    want.tally[KIND_INVALID]);
            end
        end
    end

    // Result-side stalls: a randomly chosen stall mode drives tready.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= (cycle_count % 5 != 0);
        endcase
    end

    // Watchdog: too long without any word moving on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d lines outstanding", pending_lines.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tlast   = 1'b0;
        i_m_tready  = 1'b0;
        fail_count  = 0;
        lines_checked = 0;
        bytes_sent  = 0;
        burst_left  = 0;
        idle_cycles = 0;
        cycle_count = 0;
        stall_mode  = 0;
        stall_left  = 0;
        clear_line_state();
        for (int k = 0; k < NUM_KINDS; k++) kind_tally[k] = '0;

        // Directed text: one line per special case, expected kinds typed in.
        directed_rows = '{
            // Empty line right after reset.
            '{CH_NL,    1'b0, 1'b1, KIND_SPACE,   ERR_NONE,     1'b0, 1'b0, 6'd0},
            // Two slashes make a comment.
            '{CH_SLASH, 1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{CH_SLASH, 1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{CH_NL,    1'b0, 1'b1, KIND_COMMENT, ERR_NONE,     1'b0, 1'b0, 6'd0},
            // Leading space with later text.
            '{CH_SPACE, 1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{8'h61,    1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{CH_NL,    1'b0, 1'b1, KIND_INVALID, ERR_EMPTY,    1'b0, 1'b0, 6'd0},
            // A single slash.
            '{CH_SLASH, 1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{CH_NL,    1'b0, 1'b1, KIND_INVALID, ERR_SLASH,    1'b0, 1'b0, 6'd0},
            // Two dots in a row.
            '{CH_DOT,   1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{CH_DOT,   1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{CH_NL,    1'b0, 1'b1, KIND_INVALID, ERR_ADJACENT, 1'b0, 1'b0, 6'd0},
            // A lone exclamation mark has no last label.
            '{CH_BANG,  1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{CH_NL,    1'b0, 1'b1, KIND_INVALID, ERR_TRAILING, 1'b0, 1'b0, 6'd0},
            // Wildcard rule with text after the first space.
            '{CH_STAR,  1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{CH_DOT,   1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{8'h61,    1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{CH_SPACE, 1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{8'h62,    1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{CH_NL,    1'b0, 1'b1, KIND_RULE,    ERR_NONE,     1'b0, 1'b1, 6'd2},
            // Exception rule closed by end of text on the top byte value.
            '{CH_BANG,  1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{8'hFF,    1'b1, 1'b1, KIND_RULE,    ERR_NONE,     1'b1, 1'b0, 6'd1},
            // Byte zero is label text; newline with end of text.
            '{8'h00,    1'b0, 1'b0, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd0},
            '{CH_NL,    1'b1, 1'b1, KIND_RULE,    ERR_NONE,     1'b0, 1'b0, 6'd1}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) send_text(directed_rows[i]);
        while (bytes_sent < TEXT_BYTES) send_random_line();
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;

        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Streamed %0d text bytes; %0d result words checked.", bytes_sent, lines_checked);
        $display("Lines by kind: %0d rules, %0d blank, %0d comments, %0d invalid.",
                 kind_tally[KIND_RULE], kind_tally[KIND_SPACE],
                 kind_tally[KIND_COMMENT], kind_tally[KIND_INVALID]);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
